/* hw/rtl/mec4p_pkg.sv */
// Shared widths, latencies and types for the minimum enclosing circle block.
// Used by every module under hw/rtl; depends on nothing else.
package mec4p_pkg;

    localparam int CW       = 24;               // coordinate width, signed
    localparam int DW       = CW + 1;           // coordinate difference width
    localparam int PW       = 2 * DW;           // product of two differences
    localparam int SW       = PW;               // sum of two squares, unsigned
    localparam int DDW      = PW + 2;           // twice the cross product, signed
    localparam int NW       = 3 * CW + 4;       // circumcenter numerator, signed
    localparam int QW       = CW + 1;           // quotient magnitude bits
    localparam int RW       = CW + 1;           // radius width
    localparam int SLW      = 16;               // slack register width
    localparam int LW       = ((RW > SLW) ? RW : SLW) + 1;
    localparam int DIV_LAT  = QW + 1;
    localparam int SB_LAT   = DIV_LAT + 4;
    localparam int LANE_LAT = QW + RW + 13;
    localparam int AW       = 3;                // APB address width

    localparam logic [AW-3:0] REG_SLACK = '0;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_pt;

    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
    } t_vec;

    // Values that ride alongside the divider until the circle is chosen.
    typedef struct packed {
        t_pt             dc;
        logic [SW-3:0]   dsq;
        logic            circ;
        t_pt             pa;
        t_pt             pq;
    } t_sb;

    typedef struct packed {
        t_pt c;
        t_pt q;
    } t_cq;

    typedef struct packed {
        logic                 holds;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [RW-1:0]        r;
    } t_lane_res;

endpackage

/* hw/rtl/mec4p_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with floor rounding.
// Depends on mec4p_pkg.
module mec4p_div import mec4p_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NW-1:0]        i_num,
    input  logic [DDW-1:0]       i_den,
    input  logic                 i_neg,
    output logic signed [QW:0]   o_quo
);

    logic [NW-1:0]  r_rem [QW];
    logic [DDW-1:0] r_den [QW];
    logic [QW-1:0]  r_quo [QW];
    logic           r_neg [QW];
    logic signed [QW:0] r_quo_out;

    logic [NW-1:0]  w_rem   [QW];
    logic [NW-1:0]  w_trial [QW];
    logic [DDW-1:0] w_den   [QW];
    logic [QW-1:0]  w_quo   [QW];
    logic           w_neg   [QW];
    logic [QW:0]    w_qs;

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                w_rem[k] = i_num;
                w_den[k] = i_den;
                w_quo[k] = '0;
                w_neg[k] = i_neg;
            end else begin
                w_rem[k] = r_rem[k-1];
                w_den[k] = r_den[k-1];
                w_quo[k] = r_quo[k-1];
                w_neg[k] = r_neg[k-1];
            end
            w_trial[k] = {{(NW-DDW){1'b0}}, w_den[k]} << (QW - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                if (w_rem[k] >= w_trial[k]) begin
                    r_rem[k] <= w_rem[k] - w_trial[k];
                    r_quo[k] <= w_quo[k] | (QW'(1) << (QW - 1 - k));
                end else begin
                    r_rem[k] <= w_rem[k];
                    r_quo[k] <= w_quo[k];
                end
                r_den[k] <= w_den[k];
                r_neg[k] <= w_neg[k];
            end
        end
    end

    // A negative quotient rounds toward minus infinity: -q, or -q-1 with a remainder.
    assign w_qs = {1'b0, r_quo[QW-1]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[QW-1]) begin
                r_quo_out <= $signed(~w_qs + (QW+1)'(r_rem[QW-1] == '0));
            end else begin
                r_quo_out <= $signed(w_qs);
            end
        end
    end

    assign o_quo = r_quo_out;

endmodule

/* hw/rtl/mec4p_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
// Depends on mec4p_pkg.
module mec4p_sqrt import mec4p_pkg::*; (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_sq,
    output logic [RW-1:0] o_root
);

    logic [SW:0]   r_rem  [RW];
    logic [RW-1:0] r_root [RW];

    logic [SW:0]   w_rem   [RW];
    logic [SW:0]   w_trial [RW];
    logic [RW-1:0] w_root  [RW];

    // The remainder holds the operand minus the square of the root so far.
    always_comb begin
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                w_rem[k]  = {1'b0, i_sq};
                w_root[k] = '0;
            end else begin
                w_rem[k]  = r_rem[k-1];
                w_root[k] = r_root[k-1];
            end
            w_trial[k] = ({{(SW+1-RW){1'b0}}, w_root[k]} << (RW - k))
                       | ((SW+1)'(1) << (2 * (RW - 1 - k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                if (w_rem[k] >= w_trial[k]) begin
                    r_rem[k]  <= w_rem[k] - w_trial[k];
                    r_root[k] <= w_root[k] | (RW'(1) << (RW - 1 - k));
                end else begin
                    r_rem[k]  <= w_rem[k];
                    r_root[k] <= w_root[k];
                end
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

/* hw/rtl/mec4p_lane.sv */
// One lane: smallest circle of a point triple and the containment test of a fourth point.
// Depends on mec4p_pkg, mec4p_div and mec4p_sqrt.
module mec4p_lane import mec4p_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  t_pt             i_pa,
    input  t_pt             i_pb,
    input  t_pt             i_pc,
    input  t_pt             i_pq,
    input  logic [SLW-1:0]  i_slack,
    output t_lane_res       o_res
);

    localparam int CMPW = ((SW + 1) > (2 * LW)) ? (SW + 1) : (2 * LW);

    // Stage 1: edge vectors and midpoints.
    t_vec r1_eab, r1_eac, r1_ebc;
    t_pt  r1_cab, r1_cac, r1_cbc, r1_pa, r1_pq;
    logic signed [DW-1:0] w_sab_x, w_sab_y, w_sac_x, w_sac_y, w_sbc_x, w_sbc_y;

    assign w_sab_x = DW'(i_pa.x) + DW'(i_pb.x);
    assign w_sab_y = DW'(i_pa.y) + DW'(i_pb.y);
    assign w_sac_x = DW'(i_pa.x) + DW'(i_pc.x);
    assign w_sac_y = DW'(i_pa.y) + DW'(i_pc.y);
    assign w_sbc_x = DW'(i_pb.x) + DW'(i_pc.x);
    assign w_sbc_y = DW'(i_pb.y) + DW'(i_pc.y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_eab.x <= DW'(i_pb.x) - DW'(i_pa.x);
            r1_eab.y <= DW'(i_pb.y) - DW'(i_pa.y);
            r1_eac.x <= DW'(i_pc.x) - DW'(i_pa.x);
            r1_eac.y <= DW'(i_pc.y) - DW'(i_pa.y);
            r1_ebc.x <= DW'(i_pc.x) - DW'(i_pb.x);
            r1_ebc.y <= DW'(i_pc.y) - DW'(i_pb.y);
            r1_cab.x <= w_sab_x[CW:1];
            r1_cab.y <= w_sab_y[CW:1];
            r1_cac.x <= w_sac_x[CW:1];
            r1_cac.y <= w_sac_y[CW:1];
            r1_cbc.x <= w_sbc_x[CW:1];
            r1_cbc.y <= w_sbc_y[CW:1];
            r1_pa    <= i_pa;
            r1_pq    <= i_pq;
        end
    end

    // Stage 2: dot products at each vertex, cross product and side lengths, as products.
    logic signed [PW-1:0] r2_m [14];
    t_vec r2_eab, r2_eac;
    t_pt  r2_cab, r2_cac, r2_cbc, r2_pa, r2_pq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_m[0]  <= r1_eab.x * r1_eac.x;
            r2_m[1]  <= r1_eab.y * r1_eac.y;
            r2_m[2]  <= r1_eab.x * r1_ebc.x;
            r2_m[3]  <= r1_eab.y * r1_ebc.y;
            r2_m[4]  <= r1_eac.x * r1_ebc.x;
            r2_m[5]  <= r1_eac.y * r1_ebc.y;
            r2_m[6]  <= r1_eab.x * r1_eac.y;
            r2_m[7]  <= r1_eab.y * r1_eac.x;
            r2_m[8]  <= r1_eab.x * r1_eab.x;
            r2_m[9]  <= r1_eab.y * r1_eab.y;
            r2_m[10] <= r1_eac.x * r1_eac.x;
            r2_m[11] <= r1_eac.y * r1_eac.y;
            r2_m[12] <= r1_ebc.x * r1_ebc.x;
            r2_m[13] <= r1_ebc.y * r1_ebc.y;
            r2_eab   <= r1_eab;
            r2_eac   <= r1_eac;
            r2_cab   <= r1_cab;
            r2_cac   <= r1_cac;
            r2_cbc   <= r1_cbc;
            r2_pa    <= r1_pa;
            r2_pq    <= r1_pq;
        end
    end

    // Stage 3: vertex tests pick a diameter circle, else the circumcircle.
    logic signed [PW:0]    w_dot0, w_dot1n, w_dot2;
    logic signed [DDW-1:0] w_d;
    logic [SW-1:0]         w_sa, w_sb, w_sc;
    logic                  w_na0, w_na1, w_na2;
    t_sb                   w_sb3;

    assign w_dot0  = (PW+1)'(r2_m[0]) + (PW+1)'(r2_m[1]);
    assign w_dot1n = (PW+1)'(r2_m[2]) + (PW+1)'(r2_m[3]);
    assign w_dot2  = (PW+1)'(r2_m[4]) + (PW+1)'(r2_m[5]);
    assign w_d     = (DDW'(r2_m[6]) - DDW'(r2_m[7])) <<< 1;
    assign w_sa    = $unsigned(r2_m[8])  + $unsigned(r2_m[9]);
    assign w_sb    = $unsigned(r2_m[10]) + $unsigned(r2_m[11]);
    assign w_sc    = $unsigned(r2_m[12]) + $unsigned(r2_m[13]);

    // The dot product at the second vertex is the negated sum.
    assign w_na0 = w_dot0[PW] || (w_dot0 == '0);
    assign w_na1 = !w_dot1n[PW];
    assign w_na2 = w_dot2[PW] || (w_dot2 == '0);

    always_comb begin
        w_sb3.pa   = r2_pa;
        w_sb3.pq   = r2_pq;
        w_sb3.circ = !w_na0 && !w_na1 && !w_na2 && (w_d != '0);
        if (w_na0) begin
            w_sb3.dc  = r2_cbc;
            w_sb3.dsq = w_sc[SW-1:2];
        end else if (w_na1) begin
            w_sb3.dc  = r2_cac;
            w_sb3.dsq = w_sb[SW-1:2];
        end else begin
            w_sb3.dc  = r2_cab;
            w_sb3.dsq = w_sa[SW-1:2];
        end
    end

    t_sb                   r3_sb;
    t_vec                  r3_eab, r3_eac;
    logic [SW-1:0]         r3_sa, r3_sb_len;
    logic signed [DDW-1:0] r3_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sb     <= w_sb3;
            r3_eab    <= r2_eab;
            r3_eac    <= r2_eac;
            r3_sa     <= w_sa;
            r3_sb_len <= w_sb;
            r3_d      <= w_d;
        end
    end

    // Stage 4: partial products of the cubic numerators, squared lengths split in halves.
    logic signed [2*DW:0]  r4_p [8];
    logic signed [DDW-1:0] r4_d;
    logic signed [DW:0]    w_sal, w_sah, w_sbl, w_sbh;

    assign w_sal = $signed({1'b0, r3_sa[DW-1:0]});
    assign w_sah = $signed({1'b0, r3_sa[SW-1:DW]});
    assign w_sbl = $signed({1'b0, r3_sb_len[DW-1:0]});
    assign w_sbh = $signed({1'b0, r3_sb_len[SW-1:DW]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_p[0] <= r3_eac.y * w_sal;
            r4_p[1] <= r3_eac.y * w_sah;
            r4_p[2] <= r3_eab.y * w_sbl;
            r4_p[3] <= r3_eab.y * w_sbh;
            r4_p[4] <= r3_eab.x * w_sbl;
            r4_p[5] <= r3_eab.x * w_sbh;
            r4_p[6] <= r3_eac.x * w_sal;
            r4_p[7] <= r3_eac.x * w_sah;
            r4_d    <= r3_d;
        end
    end

    // Stage 5: join the halves.
    logic signed [NW-1:0]  r5_t [4];
    logic signed [DDW-1:0] r5_d;
    logic signed [NW-1:0]  w_ext [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_ext[k] = {{(NW-2*DW-1){r4_p[k][2*DW]}}, r4_p[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r5_t[k] <= (w_ext[2*k+1] <<< DW) + w_ext[2*k];
            end
            r5_d <= r4_d;
        end
    end

    // Stage 6: numerators.
    logic signed [NW-1:0]  r6_nx, r6_ny;
    logic signed [DDW-1:0] r6_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_nx <= r5_t[0] - r5_t[1];
            r6_ny <= r5_t[2] - r5_t[3];
            r6_d  <= r5_d;
        end
    end

    // Stage 7: magnitudes and quotient signs for the dividers.
    logic [NW-1:0]  r7_nxm, r7_nym;
    logic [DDW-1:0] r7_dm;
    logic           r7_negx, r7_negy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_nxm  <= r6_nx[NW-1] ? $unsigned(-r6_nx) : $unsigned(r6_nx);
            r7_nym  <= r6_ny[NW-1] ? $unsigned(-r6_ny) : $unsigned(r6_ny);
            r7_dm   <= r6_d[DDW-1] ? $unsigned(-r6_d) : $unsigned(r6_d);
            r7_negx <= r6_nx[NW-1] ^ r6_d[DDW-1];
            r7_negy <= r6_ny[NW-1] ^ r6_d[DDW-1];
        end
    end

    logic signed [QW:0] w_ox, w_oy;

    mec4p_div u_div_x (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r7_nxm),
        .i_den (r7_dm),
        .i_neg (r7_negx),
        .o_quo (w_ox)
    );

    mec4p_div u_div_y (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r7_nym),
        .i_den (r7_dm),
        .i_neg (r7_negy),
        .o_quo (w_oy)
    );

    t_sb r_sbd [SB_LAT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sbd[0] <= r3_sb;
            for (int k = 1; k < SB_LAT; k++) begin
                r_sbd[k] <= r_sbd[k-1];
            end
        end
    end

    // Circumcenter and the squared offset that gives its radius.
    logic signed [CW+1:0]   w_ccx, w_ccy;
    t_pt                    r34_c;
    logic signed [2*QW+1:0] r34_ox2, r34_oy2;
    t_sb                    r34_sb;

    assign w_ccx = (CW+2)'(r_sbd[SB_LAT-1].pa.x) + (CW+2)'(w_ox);
    assign w_ccy = (CW+2)'(r_sbd[SB_LAT-1].pa.y) + (CW+2)'(w_oy);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r34_c.x <= w_ccx[CW-1:0];
            r34_c.y <= w_ccy[CW-1:0];
            r34_ox2 <= w_ox * w_ox;
            r34_oy2 <= w_oy * w_oy;
            r34_sb  <= r_sbd[SB_LAT-1];
        end
    end

    t_cq           r35_cq;
    logic [SW-1:0] r35_sq;
    logic [SW-1:0] w_sqc;

    assign w_sqc = r34_ox2[SW-1:0] + r34_oy2[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r35_cq.q <= r34_sb.pq;
            if (r34_sb.circ) begin
                r35_cq.c <= r34_c;
                r35_sq   <= w_sqc;
            end else begin
                r35_cq.c <= r34_sb.dc;
                r35_sq   <= {2'b00, r34_sb.dsq};
            end
        end
    end

    logic [RW-1:0] w_root;

    mec4p_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_sq   (r35_sq),
        .o_root (w_root)
    );

    t_cq r_cqd [RW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cqd[0] <= r35_cq;
            for (int k = 1; k < RW; k++) begin
                r_cqd[k] <= r_cqd[k-1];
            end
        end
    end

    // Containment: squared distance against the squared slackened radius.
    logic signed [DW-1:0] r61_dx, r61_dy;
    logic [LW-1:0]        r61_lim;
    t_pt                  r61_c;
    logic [RW-1:0]        r61_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r61_dx  <= DW'(r_cqd[RW-1].c.x) - DW'(r_cqd[RW-1].q.x);
            r61_dy  <= DW'(r_cqd[RW-1].c.y) - DW'(r_cqd[RW-1].q.y);
            r61_lim <= LW'(w_root) + LW'(i_slack);
            r61_c   <= r_cqd[RW-1].c;
            r61_r   <= w_root;
        end
    end

    logic signed [PW-1:0] r62_dx2, r62_dy2;
    logic [2*LW-1:0]      r62_lim2;
    t_pt                  r62_c;
    logic [RW-1:0]        r62_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r62_dx2  <= r61_dx * r61_dx;
            r62_dy2  <= r61_dy * r61_dy;
            r62_lim2 <= r61_lim * r61_lim;
            r62_c    <= r61_c;
            r62_r    <= r61_r;
        end
    end

    t_lane_res r63_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r63_res.holds <= (CMPW'($unsigned(r62_dx2)) + CMPW'($unsigned(r62_dy2)))
                             <= CMPW'(r62_lim2);
            r63_res.cx    <= r62_c.x;
            r63_res.cy    <= r62_c.y;
            r63_res.r     <= r62_r;
        end
    end

    assign o_res = r63_res;

endmodule

/* hw/rtl/min_enclosing_circle_four_points.sv */
// Smallest enclosing circle of three or four points: top level with APB slack register.
// An accepted input beat passes through 63 lane stages, the first loaded at the accepting
// edge, then the output register; throughput one beat per cycle, set by the fully pipelined
// lanes, dividers and square roots. The whole pipeline holds while the output beat waits.
// Reset clears the stage valid bits, the output valid and the slack register.
// Depends on mec4p_pkg and mec4p_lane.
module min_enclosing_circle_four_points import mec4p_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AW-1:0]        paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic signed [CW-1:0] i_point0_x,
    input  logic signed [CW-1:0] i_point0_y,
    input  logic signed [CW-1:0] i_point1_x,
    input  logic signed [CW-1:0] i_point1_y,
    input  logic signed [CW-1:0] i_point2_x,
    input  logic signed [CW-1:0] i_point2_y,
    input  logic signed [CW-1:0] i_point3_x,
    input  logic signed [CW-1:0] i_point3_y,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [CW-1:0] o_center_x,
    output logic signed [CW-1:0] o_center_y,
    output logic [RW-1:0]        o_radius
);

    logic [SLW-1:0]      r_slack;
    logic [LANE_LAT-1:0] r_vld;
    logic [LANE_LAT-1:0] r_mode;
    logic                r_out_valid;
    t_lane_res           r_out;
    logic                w_en;
    t_pt                 w_p [4];
    t_lane_res           w_res [4];
    t_lane_res           w_sel;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slack <= '0;
        end else if (psel && penable && pwrite && (paddr[AW-1:2] == REG_SLACK)) begin
            r_slack <= pwdata[SLW-1:0];
        end
    end

    always_comb begin
        unique case (paddr[AW-1:2])
            REG_SLACK: prdata = {{(32-SLW){1'b0}}, r_slack};
            default:   prdata = '0;
        endcase
    end

    // Every stage moves together whenever the output register can take a beat.
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[LANE_LAT-2:0], i_in_valid};
            r_out_valid <= r_vld[LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mode <= {r_mode[LANE_LAT-2:0], i_mode};
        end
    end

    assign w_p[0] = '{x: i_point0_x, y: i_point0_y};
    assign w_p[1] = '{x: i_point1_x, y: i_point1_y};
    assign w_p[2] = '{x: i_point2_x, y: i_point2_y};
    assign w_p[3] = '{x: i_point3_x, y: i_point3_y};

    // Lanes hold the triples in trial order, each tested against the point it leaves out.
    mec4p_lane u_lane0 (
        .i_clk (i_clk), .i_en (w_en),
        .i_pa (w_p[0]), .i_pb (w_p[1]), .i_pc (w_p[2]), .i_pq (w_p[3]),
        .i_slack (r_slack), .o_res (w_res[0])
    );

    mec4p_lane u_lane1 (
        .i_clk (i_clk), .i_en (w_en),
        .i_pa (w_p[0]), .i_pb (w_p[1]), .i_pc (w_p[3]), .i_pq (w_p[2]),
        .i_slack (r_slack), .o_res (w_res[1])
    );

    mec4p_lane u_lane2 (
        .i_clk (i_clk), .i_en (w_en),
        .i_pa (w_p[0]), .i_pb (w_p[2]), .i_pc (w_p[3]), .i_pq (w_p[1]),
        .i_slack (r_slack), .o_res (w_res[2])
    );

    mec4p_lane u_lane3 (
        .i_clk (i_clk), .i_en (w_en),
        .i_pa (w_p[1]), .i_pb (w_p[2]), .i_pc (w_p[3]), .i_pq (w_p[0]),
        .i_slack (r_slack), .o_res (w_res[3])
    );

    // The first triple whose circle holds the left-out point wins; the last one is kept
    // if none does. Three-point items always take the first triple.
    always_comb begin
        if (!r_mode[LANE_LAT-1] || w_res[0].holds) begin
            w_sel = w_res[0];
        end else if (w_res[1].holds) begin
            w_sel = w_res[1];
        end else if (w_res[2].holds) begin
            w_sel = w_res[2];
        end else begin
            w_sel = w_res[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_sel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_center_x  = r_out.cx;
    assign o_center_y  = r_out.cy;
    assign o_radius    = r_out.r;

endmodule
